@@ rtl/core/rbd_pkg.sv @@
// Shared types and constants for the range breakout detector.
package rbd_pkg;

    localparam int RBD_DEPTH  = 256;
    localparam int PX_W       = 32;
    localparam int TS_W       = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUDGE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_UP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_DN = 3'd6;

    // open signal codes
    localparam logic [1:0] SIG_NONE  = 2'd0;
    localparam logic [1:0] SIG_LONG  = 2'd1;
    localparam logic [1:0] SIG_SHORT = 2'd2;

    typedef struct packed {
        logic [TS_W-1:0] window_s;
        logic [TS_W-1:0] judge_s;
        logic [30:0]     target;
        logic [15:0]     tol;
        logic [30:0]     margin;
        logic            allow_up;
        logic            allow_dn;
    } t_cfg;

endpackage

@@ rtl/core/rbd_ram.sv @@
// Generic single write, single read RAM with registered read data.
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rbd_cfg.sv @@
// Configuration register file of the range breakout detector.
module rbd_cfg
    import rbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{window_s: '0, judge_s: '0, target: '0, tol: 16'd1, margin: '0,
                       allow_up: 1'b0, allow_dn: 1'b0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW:   r_cfg.window_s <= i_cfg_data[TS_W-1:0];
                CFG_JUDGE:    r_cfg.judge_s  <= i_cfg_data[TS_W-1:0];
                CFG_TARGET:   r_cfg.target   <= i_cfg_data[30:0];
                CFG_TOL:      r_cfg.tol      <= i_cfg_data[15:0];
                CFG_MARGIN:   r_cfg.margin   <= i_cfg_data[30:0];
                CFG_ALLOW_UP: r_cfg.allow_up <= i_cfg_data[0];
                CFG_ALLOW_DN: r_cfg.allow_dn <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/rbd_ctrl.sv @@
// Sequencer of the range breakout detector: window ring, extremes, rescans, judging.
module rbd_ctrl
    import rbd_pkg::*;
#(
    parameter int DEPTH = RBD_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [PX_W-1:0]   i_price,
    input  logic [TS_W-1:0]          i_timestamp,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_open_signal,
    output logic                     o_armed,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [PX_W-1:0]          o_wr_px,
    output logic [TS_W-1:0]          o_wr_ts,
    output logic [$clog2(DEPTH)-1:0] o_px_raddr,
    input  logic [PX_W-1:0]          i_px_rdata,
    output logic [$clog2(DEPTH)-1:0] o_ts_raddr,
    input  logic [TS_W-1:0]          i_ts_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_W = (CW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_FAILCLR, S_STORE, S_STORE_WR, S_EVICT, S_SCAN_INIT,
        S_SCAN, S_SCAN_APPLY, S_EVAL_A, S_EVAL_B, S_IR_UPD, S_LOOP_RD, S_LOOP_CMP,
        S_FINISH
    } t_state;

    function automatic logic [AW-1:0] f_wrap(input logic [CW:0] a);
        logic [CW:0] t;
        t = (a >= DEPTH_W) ? a - DEPTH_W : a;
        return t[AW-1:0];
    endfunction

    t_state r_state, n_state;
    t_state r_ret_store, n_ret_store, r_ret_evict, n_ret_evict;
    t_state r_ret_eval, n_ret_eval, r_ret_scan, n_ret_scan;
    logic signed [PX_W-1:0] r_px, n_px, r_hi_px, n_hi_px, r_lo_px, n_lo_px;
    logic signed [PX_W-1:0] r_bh_px, n_bh_px, r_bl_px, n_bl_px;
    logic [TS_W-1:0] r_ts, n_ts, r_js, n_js;
    logic [AW-1:0]   r_head, n_head, r_hi_slot, n_hi_slot, r_lo_slot, n_lo_slot;
    logic [AW-1:0]   r_wslot, n_wslot, r_pslot, n_pslot, r_bh_slot, n_bh_slot;
    logic [AW-1:0]   r_bl_slot, n_bl_slot;
    logic [CW-1:0]   r_count, n_count, r_si, n_si;
    logic r_ev, n_ev, r_pf, n_pf, r_ready, n_ready, r_bu, n_bu, r_bd, n_bd;
    logic r_need_hi, n_need_hi, r_need_lo, n_need_lo, r_do_eval, n_do_eval;
    logic r_pv, n_pv, r_first, n_first;
    logic [1:0] r_sig, n_sig, r_o_sig, n_o_sig;
    logic r_ov, n_ov, r_o_armed, n_o_armed;
    logic signed [33:0] r_d, n_d;

    logic [AW-1:0] head_next, wr_slot, scan_addr;
    logic full, gt_hi, lt_lo, up_ok, dn_ok, in_judge, age_ok, rdy_eval;
    logic signed [32:0] up_pts, dn_pts, margin_s;
    logic signed [18:0] jdiff, age;
    logic signed [33:0] d_new, d_abs;
    logic signed [PX_W-1:0] rd_px;

    // slot arithmetic and comparisons
    always_comb begin
        head_next = f_wrap((CW+1)'(r_head) + (CW+1)'(1));
        wr_slot   = f_wrap((CW+1)'(r_head) + (CW+1)'(r_count));
        scan_addr = f_wrap((CW+1)'(r_head) + (CW+1)'(r_si));
        full      = r_count == DEPTH_C;
        gt_hi     = r_px > r_hi_px;
        lt_lo     = r_px < r_lo_px;
        margin_s  = $signed({2'b00, i_cfg.margin});
        up_pts    = $signed({r_px[PX_W-1], r_px}) - $signed({r_hi_px[PX_W-1], r_hi_px});
        dn_pts    = $signed({r_lo_px[PX_W-1], r_lo_px}) - $signed({r_px[PX_W-1], r_px});
        up_ok     = up_pts >= margin_s;
        dn_ok     = dn_pts >= margin_s;
        jdiff     = $signed({2'b00, r_ts}) - $signed({2'b00, r_js});
        in_judge  = jdiff < $signed({2'b00, i_cfg.judge_s});
        age       = $signed({2'b00, r_ts}) - $signed({2'b00, i_ts_rdata});
        age_ok    = age <= $signed({2'b00, i_cfg.window_s});
        d_new     = $signed({{2{r_hi_px[PX_W-1]}}, r_hi_px})
                  - $signed({{2{r_lo_px[PX_W-1]}}, r_lo_px})
                  - $signed({3'b000, i_cfg.target});
        d_abs     = r_d[33] ? -r_d : r_d;
        rdy_eval  = d_abs < $signed({18'd0, i_cfg.tol});
        rd_px     = $signed(i_px_rdata);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_ret_store = r_ret_store; n_ret_evict = r_ret_evict;
        n_ret_eval = r_ret_eval; n_ret_scan = r_ret_scan;
        n_px = r_px; n_ts = r_ts; n_js = r_js;
        n_hi_px = r_hi_px; n_lo_px = r_lo_px; n_bh_px = r_bh_px; n_bl_px = r_bl_px;
        n_head = r_head; n_count = r_count; n_hi_slot = r_hi_slot; n_lo_slot = r_lo_slot;
        n_wslot = r_wslot; n_pslot = r_pslot; n_bh_slot = r_bh_slot; n_bl_slot = r_bl_slot;
        n_si = r_si; n_pv = 1'b0; n_first = r_first;
        n_ev = r_ev; n_pf = r_pf; n_ready = r_ready; n_bu = r_bu; n_bd = r_bd;
        n_need_hi = r_need_hi; n_need_lo = r_need_lo; n_do_eval = r_do_eval;
        n_sig = r_sig; n_d = r_d;
        n_ov = r_ov && i_stall; n_o_sig = r_o_sig; n_o_armed = r_o_armed;
        o_we = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_px = i_price;
                    n_ts = i_timestamp;
                    n_sig = SIG_NONE;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_ret_store = S_IR_UPD;
                n_state = S_STORE;
                if (r_ready && r_ev) begin
                    if (!r_bu && !r_bd) begin
                        if (i_cfg.allow_up && gt_hi) begin
                            n_bu = 1'b1;
                            n_js = r_ts;
                            n_ret_store = S_FINISH;
                        end else if (i_cfg.allow_dn && lt_lo) begin
                            n_bd = 1'b1;
                            n_js = r_ts;
                            n_ret_store = S_FINISH;
                        end
                    end else if (in_judge) begin
                        n_ret_store = S_FINISH;
                    end else if ((r_bu && up_ok) || (!r_bu && dn_ok)) begin
                        n_sig = r_bu ? SIG_LONG : SIG_SHORT;
                        n_state = S_FINISH;
                    end else begin
                        // failed breakout: the broken extreme is rescanned from the whole window
                        n_need_hi = r_bu;
                        n_need_lo = !r_bu;
                        n_do_eval = 1'b0;
                        n_ret_scan = S_FAILCLR;
                        n_state = S_SCAN_INIT;
                    end
                end
            end
            S_FAILCLR: begin
                n_ready = 1'b0;
                n_bu = 1'b0;
                n_bd = 1'b0;
                n_ret_store = S_IR_UPD;
                n_state = S_STORE;
            end
            S_STORE: begin
                if (full) begin
                    n_ret_evict = S_STORE_WR;
                    n_state = S_EVICT;
                end else begin
                    n_state = S_STORE_WR;
                end
            end
            S_STORE_WR: begin
                o_we = 1'b1;
                n_wslot = wr_slot;
                n_count = r_count + CW'(1);
                n_state = r_ret_store;
            end
            S_EVICT: begin
                n_head = head_next;
                n_count = r_count - CW'(1);
                n_state = r_ret_evict;
                if (r_count == CW'(1)) begin
                    n_ev = 1'b0;
                end else if (r_ev && (r_hi_slot == r_head || r_lo_slot == r_head)) begin
                    n_need_hi = r_hi_slot == r_head;
                    n_need_lo = r_lo_slot == r_head;
                    n_do_eval = 1'b1;
                    n_ret_eval = r_ret_evict;
                    n_state = S_SCAN_INIT;
                end
            end
            S_SCAN_INIT: begin
                n_si = '0;
                n_first = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // issue one read a cycle, fold in the data of the previous one
                if (r_si != r_count) begin
                    n_si = r_si + CW'(1);
                    n_pv = 1'b1;
                    n_pslot = scan_addr;
                end
                if (r_pv) begin
                    n_first = 1'b0;
                    if (r_first || rd_px > r_bh_px) begin
                        n_bh_px = rd_px;
                        n_bh_slot = r_pslot;
                    end
                    if (r_first || rd_px < r_bl_px) begin
                        n_bl_px = rd_px;
                        n_bl_slot = r_pslot;
                    end
                end
                if (r_si == r_count && !r_pv) begin
                    n_state = S_SCAN_APPLY;
                end
            end
            S_SCAN_APPLY: begin
                if (r_need_hi) begin
                    n_hi_px = r_bh_px;
                    n_hi_slot = r_bh_slot;
                end
                if (r_need_lo) begin
                    n_lo_px = r_bl_px;
                    n_lo_slot = r_bl_slot;
                end
                n_state = r_do_eval ? S_EVAL_A : r_ret_scan;
            end
            S_EVAL_A: begin
                if (r_ev && r_pf) begin
                    n_d = d_new;
                    n_state = S_EVAL_B;
                end else begin
                    n_state = r_ret_eval;
                end
            end
            S_EVAL_B: begin
                n_ready = rdy_eval;
                n_state = r_ret_eval;
            end
            S_IR_UPD: begin
                n_ret_eval = S_LOOP_RD;
                n_state = S_LOOP_RD;
                if (!r_ev) begin
                    n_ev = 1'b1;
                    n_hi_px = r_px;
                    n_lo_px = r_px;
                    n_hi_slot = r_wslot;
                    n_lo_slot = r_wslot;
                    n_state = S_EVAL_A;
                end else if (gt_hi || lt_lo) begin
                    if (gt_hi) begin
                        n_hi_px = r_px;
                        n_hi_slot = r_wslot;
                    end
                    if (lt_lo) begin
                        n_lo_px = r_px;
                        n_lo_slot = r_wslot;
                    end
                    n_state = S_EVAL_A;
                end
            end
            S_LOOP_RD: begin
                n_state = (r_count == '0) ? S_FINISH : S_LOOP_CMP;
            end
            S_LOOP_CMP: begin
                if (age_ok) begin
                    n_state = S_FINISH;
                end else begin
                    n_pf = 1'b1;
                    n_ret_evict = S_LOOP_RD;
                    n_state = S_EVICT;
                end
            end
            S_FINISH: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_o_sig = r_sig;
                    n_o_armed = r_ready;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0; r_count <= '0; r_hi_slot <= '0; r_lo_slot <= '0;
            r_ev <= 1'b0; r_pf <= 1'b0; r_ready <= 1'b0; r_bu <= 1'b0; r_bd <= 1'b0;
            r_js <= '0; r_pv <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head; r_count <= n_count;
            r_hi_slot <= n_hi_slot; r_lo_slot <= n_lo_slot;
            r_ev <= n_ev; r_pf <= n_pf; r_ready <= n_ready; r_bu <= n_bu; r_bd <= n_bd;
            r_js <= n_js; r_pv <= n_pv; r_ov <= n_ov;
        end
        r_ret_store <= n_ret_store; r_ret_evict <= n_ret_evict;
        r_ret_eval <= n_ret_eval; r_ret_scan <= n_ret_scan;
        r_px <= n_px; r_ts <= n_ts; r_hi_px <= n_hi_px; r_lo_px <= n_lo_px;
        r_bh_px <= n_bh_px; r_bl_px <= n_bl_px; r_bh_slot <= n_bh_slot;
        r_bl_slot <= n_bl_slot; r_wslot <= n_wslot; r_pslot <= n_pslot;
        r_si <= n_si; r_first <= n_first; r_need_hi <= n_need_hi;
        r_need_lo <= n_need_lo; r_do_eval <= n_do_eval; r_sig <= n_sig; r_d <= n_d;
        r_o_sig <= n_o_sig; r_o_armed <= n_o_armed;
    end

    assign o_stall       = r_state != S_IDLE;
    assign o_valid       = r_ov;
    assign o_open_signal = r_o_sig;
    assign o_armed       = r_o_armed;
    assign o_waddr       = wr_slot;
    assign o_wr_px       = r_px;
    assign o_wr_ts       = r_ts;
    assign o_px_raddr    = scan_addr;
    assign o_ts_raddr    = r_head;

endmodule

@@ rtl/core/range_breakout_detector.sv @@
// Top level of the range breakout detector: registers, sequencer and window stores.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------
//  input    | i_valid / o_stall  | i_price, i_timestamp
//  result   | o_valid / i_stall  | o_open_signal, o_armed
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// A confirmed open goes straight to its result; a breakout or judging quote is
// stored first; any other quote is stored, updates the extremes and ages the window.
// Each eviction of an extreme rescans it, as the single price read port walks the
// ring one slot a cycle. One quote may age out the whole window.
// Reset is synchronous and clears the ring pointers and flags; no clearing pass.
// o_stall is high from the transfer of a quote until its result is registered;
// a held result blocks only the completion of the next quote.
module range_breakout_detector
    import rbd_pkg::*;
#(
    parameter int WINDOW_DEPTH = RBD_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [PX_W-1:0] i_price,
    input  logic [TS_W-1:0]        i_timestamp,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_open_signal,
    output logic                   o_armed
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    t_cfg            cfg;
    logic            we;
    logic [AW-1:0]   waddr, px_raddr, ts_raddr;
    logic [PX_W-1:0] wr_px, px_rdata;
    logic [TS_W-1:0] wr_ts, ts_rdata;

    rbd_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    rbd_ctrl #(.DEPTH(WINDOW_DEPTH)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_price(i_price), .i_timestamp(i_timestamp),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_open_signal(o_open_signal), .o_armed(o_armed),
        .o_we(we), .o_waddr(waddr), .o_wr_px(wr_px), .o_wr_ts(wr_ts),
        .o_px_raddr(px_raddr), .i_px_rdata(px_rdata),
        .o_ts_raddr(ts_raddr), .i_ts_rdata(ts_rdata)
    );

    // window prices
    rbd_ram #(.WIDTH(PX_W), .DEPTH(WINDOW_DEPTH)) u_px_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wr_px),
        .i_raddr(px_raddr), .o_rdata(px_rdata)
    );

    // window timestamps
    rbd_ram #(.WIDTH(TS_W), .DEPTH(WINDOW_DEPTH)) u_ts_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wr_ts),
        .i_raddr(ts_raddr), .o_rdata(ts_rdata)
    );

endmodule

@@ test/tb_range_breakout_detector.sv @@
// Self-checking testbench for the range breakout detector.
`timescale 1ns / 1ps

module tb_range_breakout_detector;
    import rbd_pkg::*;

    localparam int RING      = RBD_DEPTH;
    localparam int WDOG_MAX  = 200000;
    localparam int PHASE_LEN = 330;
    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [1:0] sig;
        logic       armed;
    } t_quote_res;

    typedef struct {
        int         px;
        int         ts;
        bit         typed;
        t_quote_res res;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [PX_W-1:0] i_price;
    logic [TS_W-1:0]        i_timestamp;
    logic                   o_valid;
    logic                   i_stall;
    logic [1:0]             o_open_signal;
    logic                   o_armed;

    range_breakout_detector u_top (.*);

    // mirror of the block state
    t_cfg        regs;
    int          px_ring [RING];
    int          ts_ring [RING];
    int unsigned ring_head, ring_count, hi_slot, lo_slot;
    int          judge_t0;
    bit          have_ext, win_filled, is_armed, brk_up, brk_dn;

    // expected results in transfer order
    t_quote_res  exp_fifo [EXP_DEPTH];
    int          exp_wr, exp_rd;
    int          err_cnt;
    int          quote_cnt, res_cnt, long_cnt, short_cnt, armed_cnt;
    bit          quiet;
    int          tx_stall_left;
    int          wdog;

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic void recheck_range();
        longint rng, d;
        if (!have_ext) return;
        rng = longint'(px_ring[hi_slot]) - longint'(px_ring[lo_slot]);
        if (win_filled) begin
            d = rng - longint'(regs.target);
            if (d < 0) d = -d;
            is_armed = d < longint'(regs.tol);
        end
    endfunction

    function automatic void set_hi(int unsigned s);
        hi_slot = s;
        recheck_range();
    endfunction

    function automatic void set_lo(int unsigned s);
        lo_slot = s;
        recheck_range();
    endfunction

    // oldest extreme wins ties
    function automatic int unsigned find_extreme(bit want_high);
        int unsigned best, s;
        best = ring_head;
        for (int unsigned i = 1; i < ring_count; i++) begin
            s = (ring_head + i) % RING;
            if (want_high ? px_ring[s] > px_ring[best] : px_ring[s] < px_ring[best])
                best = s;
        end
        return best;
    endfunction

    function automatic void drop_oldest();
        int unsigned s;
        bit hp, lp;
        s = ring_head;
        if (ring_count == 0) return;
        ring_head  = (ring_head + 1) % RING;
        ring_count = ring_count - 1;
        if (ring_count == 0) begin
            have_ext = 0;
            return;
        end
        if (!have_ext) return;
        hp = (hi_slot == s);
        lp = (lo_slot == s);
        if (hp) set_hi(find_extreme(1'b1));
        if (lp) set_lo(find_extreme(1'b0));
    endfunction

    function automatic int unsigned push_quote(int px, int ts);
        int unsigned slot;
        if (ring_count >= RING) drop_oldest();
        slot = (ring_head + ring_count) % RING;
        px_ring[slot] = px;
        ts_ring[slot] = ts;
        ring_count++;
        return slot;
    endfunction

    function automatic void track_quote(int px, int ts);
        int unsigned slot;
        int age;
        slot = push_quote(px, ts);
        if (!have_ext) begin
            have_ext = 1;
            hi_slot  = slot;
            lo_slot  = slot;
            recheck_range();
        end else begin
            if (px > px_ring[hi_slot]) set_hi(slot);
            if (px < px_ring[lo_slot]) set_lo(slot);
        end
        // age out; negative ages never evict
        while (ring_count > 0) begin
            age = ts - ts_ring[ring_head];
            if (age <= int'(regs.window_s)) break;
            win_filled = 1;
            drop_oldest();
        end
    endfunction

    function automatic logic [1:0] judge_quote(int px, int ts);
        longint pts;
        if (!brk_up && !brk_dn) begin
            if (regs.allow_up && px > px_ring[hi_slot]) begin
                brk_up   = 1;
                judge_t0 = ts;
                void'(push_quote(px, ts));
                return SIG_NONE;
            end
            if (regs.allow_dn && px < px_ring[lo_slot]) begin
                brk_dn   = 1;
                judge_t0 = ts;
                void'(push_quote(px, ts));
                return SIG_NONE;
            end
            track_quote(px, ts);
            return SIG_NONE;
        end
        // still inside the judging interval
        if (ts - judge_t0 < int'(regs.judge_s)) begin
            void'(push_quote(px, ts));
            return SIG_NONE;
        end
        if (brk_up) begin
            pts = longint'(px) - longint'(px_ring[hi_slot]);
            if (pts >= longint'(regs.margin)) return SIG_LONG;
            set_hi(find_extreme(1'b1));
        end
        if (brk_dn) begin
            pts = longint'(px_ring[lo_slot]) - longint'(px);
            if (pts >= longint'(regs.margin)) return SIG_SHORT;
            set_lo(find_extreme(1'b0));
        end
        // failed breakout: disarm and treat as an ordinary quote
        is_armed = 0;
        brk_up   = 0;
        brk_dn   = 0;
        track_quote(px, ts);
        return SIG_NONE;
    endfunction

    function automatic t_quote_res predict_quote(int px, int ts);
        t_quote_res r;
        r.sig = SIG_NONE;
        if (is_armed && have_ext) r.sig = judge_quote(px, ts);
        else track_quote(px, ts);
        r.armed = is_armed;
        return r;
    endfunction

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        t_quote_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            res_cnt <= res_cnt + 1;
            if (exp_wr == exp_rd) begin
                err_cnt = err_cnt + 1;
                if (err_cnt <= 10)
                    $display("ERROR: unexpected result sig=%0d armed=%0b",
                             o_open_signal, o_armed);
            end else begin
                e = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd = exp_rd + 1;
                if (o_open_signal !== e.sig || o_armed !== e.armed) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10)
                        $display("ERROR: result %0d sig exp %0d got %0d, armed exp %0b got %0b",
                                 res_cnt, e.sig, o_open_signal, e.armed, o_armed);
                end
            end
        end
    end

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall       <= 1'b0;
            tx_stall_left <= 0;
        end else if (tx_stall_left > 0) begin
            i_stall       <= 1'b1;
            tx_stall_left <= tx_stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall       <= 1'b1;
            tx_stall_left <= $urandom_range(0, 4);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            wdog <= 0;
        end else if (wdog >= WDOG_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_regs(t_cfg c);
        logic [CFG_DATA_W-1:0] vals [7];
        logic [CFG_IDX_W-1:0]  idxs [7];
        idxs = '{CFG_WINDOW, CFG_JUDGE, CFG_TARGET, CFG_TOL, CFG_MARGIN,
                 CFG_ALLOW_UP, CFG_ALLOW_DN};
        vals = '{CFG_DATA_W'(c.window_s), CFG_DATA_W'(c.judge_s), c.target,
                 CFG_DATA_W'(c.tol), c.margin, CFG_DATA_W'(c.allow_up),
                 CFG_DATA_W'(c.allow_dn)};
        for (int k = 0; k < 7; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        regs = c;
    endtask

    // one quote transfer; valid stays high afterwards unless the next call idles or drain() drops it
    task automatic send_quote(int px, int ts, bit typed, t_quote_res want);
        t_quote_res r;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_price     <= px;
        i_timestamp <= TS_W'(ts);
        do @(posedge i_clk); while (o_stall);
        r = predict_quote(px, ts);
        exp_fifo[exp_wr % EXP_DEPTH] = typed ? want : r;
        exp_wr = exp_wr + 1;
        quote_cnt++;
        if (r.sig == SIG_LONG) long_cnt++;
        if (r.sig == SIG_SHORT) short_cnt++;
        if (r.armed) armed_cnt++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int clip_px(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    // box of quotes, a breakout, judging quotes and a deciding quote
    task automatic run_episode(ref int t, ref int left);
        longint base, box, edge_px, px;
        int n;
        bit up;
        t_quote_res none;
        none = '0;
        box  = (regs.target > 31'd100000000) ? longint'(regs.target)
                                              : longint'(regs.target) + $urandom_range(0, 2);
        base = (box > 64'sd100000000) ? -64'sd1073741824
                                      : longint'($urandom_range(0, 2000000)) - 1000000;
        n = (regs.window_s > 17'd30) ? $urandom_range(5, 40)
                                     : int'(regs.window_s) + $urandom_range(2, 12);
        for (int k = 0; k < n && left > 0; k++, left--) begin
            if ($urandom_range(0, 5) != 0) t = (t + 1) % 86400;
            if (k == 0) px = base;
            else if (k == 1) px = base + box;
            else px = base + longint'($urandom) % (box + 1);
            send_quote(clip_px(px), t, 0, none);
        end
        up      = $urandom_range(0, 1);
        edge_px = up ? base + box + $urandom_range(1, 50) : base - $urandom_range(1, 50);
        if (left > 0) begin
            t = (t + 1) % 86400;
            send_quote(clip_px(edge_px), t, 0, none);
            left--;
        end
        n = (regs.judge_s > 17'd10) ? $urandom_range(0, 6) : $urandom_range(0, regs.judge_s + 1);
        for (int k = 0; k < n && left > 0; k++, left--) begin
            t = (t + $urandom_range(0, 1)) % 86400;
            send_quote(clip_px(edge_px + longint'($urandom_range(0, 60)) - 30), t, 0, none);
        end
        if (left > 0) begin
            t = (t + int'(regs.judge_s > 17'd20 ? 17'd20 : regs.judge_s)
                   + $urandom_range(0, 2)) % 86400;
            px = edge_px + (up ? 1 : -1) * (longint'(regs.margin)
                 + longint'($urandom_range(0, 20)) - 10);
            send_quote(clip_px(px), t, 0, none);
            left--;
        end
    endtask

    task automatic run_phase(t_cfg c, bit with_pause);
        int t, left;
        t_quote_res none;
        none = '0;
        write_regs(c);
        t    = $urandom_range(0, 86399);
        left = PHASE_LEN;
        while (left > 0) begin
            if ($urandom_range(0, 6) == 0) begin
                // noise: any price and a random timestamp from 0 to 86399
                send_quote(int'($urandom), $urandom_range(0, 86399), 0, none);
                left--;
            end else begin
                run_episode(t, left);
            end
            // hold off until the block has caught up
            if (with_pause && left < PHASE_LEN / 2) begin
                drain();
                with_pause = 0;
            end
        end
        drain();
    endtask

    initial begin
        t_stim_row  rows[$];
        t_cfg       c;
        t_quote_res none;
        none          = '0;
        err_cnt       = 0;
        quote_cnt     = 0;
        res_cnt       = 0;
        long_cnt      = 0;
        short_cnt     = 0;
        armed_cnt     = 0;
        exp_wr        = 0;
        exp_rd        = 0;
        quiet         = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_WINDOW;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_price       <= '0;
        i_timestamp   <= '0;
        i_stall       <= 1'b0;
        tx_stall_left = 0;
        wdog          = 0;
        regs          = '{window_s: 0, judge_s: 0, target: 0, tol: 1, margin: 0,
                          allow_up: 0, allow_dn: 0};
        ring_head = 0; ring_count = 0; hi_slot = 0; lo_slot = 0; judge_t0 = 0;
        have_ext = 0; win_filled = 0; is_armed = 0; brk_up = 0; brk_dn = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill, arm, break up and confirm, fail, then field extremes
        write_regs('{window_s: 2, judge_s: 2, target: 100, tol: 1, margin: 10,
                     allow_up: 1, allow_dn: 1});
        rows = '{
            '{0,           0,     1, '{SIG_NONE, 1'b0}},
            '{100,         1,     1, '{SIG_NONE, 1'b0}},
            '{50,          2,     1, '{SIG_NONE, 1'b0}},
            '{60,          3,     0, '0},
            '{0,           4,     0, '0},
            '{100,         5,     0, '0},
            '{150,         6,     0, '0},
            '{120,         7,     0, '0},
            '{115,         8,     0, '0},
            '{95,          9,     0, '0},
            '{40,          10,    0, '0},
            '{-5,          11,    0, '0},
            '{-30,         12,    0, '0},
            '{-2,          14,    0, '0},
            '{-30,         15,    0, '0},
            '{2147483647,  16,    0, '0},
            '{-2147483648, 17,    0, '0},
            '{0,           86399, 0, '0},
            '{-1,          65536, 0, '0},
            '{7,           0,     0, '0},
            '{-1,          131071 % 86400, 0, '0}
        };
        foreach (rows[k]) send_quote(rows[k].px, rows[k].ts, rows[k].typed, rows[k].res);
        drain();

        // random phases, extremes of every register among them
        c = '{window_s: 20, judge_s: 5, target: 200, tol: 10, margin: 20,
              allow_up: 1, allow_dn: 1};
        run_phase(c, 1);
        c = '{window_s: 86399, judge_s: 86399, target: 31'h7fffffff, tol: 16'hffff,
              margin: 31'h7fffffff, allow_up: 0, allow_dn: 1};
        run_phase(c, 0);
        c = '{window_s: 0, judge_s: 0, target: 0, tol: 0, margin: 0,
              allow_up: 1, allow_dn: 0};
        run_phase(c, 0);
        c = '{window_s: 10, judge_s: 3, target: 50, tol: 16'hffff, margin: 0,
              allow_up: 1, allow_dn: 1};
        run_phase(c, 0);
        quiet = 1;
        c = '{window_s: 5, judge_s: 1, target: 300, tol: 20, margin: 5,
              allow_up: 1, allow_dn: 1};
        run_phase(c, 0);
        repeat (600) @(posedge i_clk);

        $display("Run covered %0d quotes over six register settings, %0d of them armed.",
                 quote_cnt, armed_cnt);
        $display("Opens seen: %0d long, %0d short; %0d results checked.",
                 long_cnt, short_cnt, res_cnt);
        if (err_cnt == 0 && exp_wr == exp_rd) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rbd_pkg.sv
rtl/core/rbd_ram.sv
rtl/core/rbd_cfg.sv
rtl/core/rbd_ctrl.sv
rtl/core/range_breakout_detector.sv
test/tb_range_breakout_detector.sv
